>>> rtl/obb_pkg.sv
// ----------------------------------------------------------------------------
// obb_pkg
// Shared widths, limits, register indexes and the result bundle of the
// opaque pixel bounding box.
// ----------------------------------------------------------------------------
package obb_pkg;

  localparam int unsigned MaxDim    = 4096;
  localparam int unsigned CoordW    = 12;
  localparam int unsigned DimW      = 13;
  localparam int unsigned ChanW     = 8;
  localparam int unsigned CfgDataW  = 13;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned InDataW   = 32;
  localparam int unsigned OutDataW  = 80;

  localparam logic [ChanW-1:0] ChanMax = 8'd255;
  localparam logic [ChanW-1:0] ChanMin = 8'd0;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_ALPHA_THRESH = 2'd2,
    CFG_TRIM_ENABLE  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic              found;
    logic [CoordW-1:0] left;
    logic [CoordW-1:0] top;
    logic [CoordW-1:0] right;
    logic [CoordW-1:0] bottom;
    logic [DimW-1:0]   trimmed_width;
    logic [DimW-1:0]   trimmed_height;
  } obb_result_t;

endpackage

>>> rtl/obb_tracker.sv
// ----------------------------------------------------------------------------
// obb_tracker
// Column and row counters plus the per-frame opaque bounds; forms the
// frame result on the last pixel.
// ----------------------------------------------------------------------------
module obb_tracker
  import obb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic                opaque_i,
  input  logic [DimW-1:0]     image_width_i,
  input  logic [DimW-1:0]     image_height_i,
  input  logic                trim_enable_i,
  output logic                frame_end_o,
  output obb_result_t         result_o
);

  logic [CoordW-1:0] col_q, col_d, row_q, row_d;
  logic [CoordW-1:0] min_col_q, min_col_d, min_row_q, min_row_d;
  logic [CoordW-1:0] max_col_q, max_col_d, max_row_q, max_row_d;
  logic              seen_q, seen_d;

  logic [DimW-1:0]   w_clamped, h_clamped;
  logic [CoordW-1:0] w_last, h_last;
  logic              row_end;
  logic [CoordW-1:0] min_col_n, min_row_n, max_col_n, max_row_n;
  logic              seen_n;
  logic [CoordW-1:0] lft, tp, rgt, bot;

  // zero acts as one, oversize acts as the limit
  always_comb begin
    if (image_width_i == '0) begin
      w_clamped = DimW'(1);
    end else if (image_width_i > DimW'(MaxDim)) begin
      w_clamped = DimW'(MaxDim);
    end else begin
      w_clamped = image_width_i;
    end
    if (image_height_i == '0) begin
      h_clamped = DimW'(1);
    end else if (image_height_i > DimW'(MaxDim)) begin
      h_clamped = DimW'(MaxDim);
    end else begin
      h_clamped = image_height_i;
    end
  end

  assign w_last = CoordW'(w_clamped - DimW'(1));
  assign h_last = CoordW'(h_clamped - DimW'(1));

  assign row_end     = (col_q >= w_last);
  assign frame_end_o = row_end && (row_q >= h_last);

  always_comb begin
    min_col_n = min_col_q;
    min_row_n = min_row_q;
    max_col_n = max_col_q;
    max_row_n = max_row_q;
    seen_n    = seen_q;
    if (opaque_i) begin
      seen_n = 1'b1;
      if (col_q < min_col_q) min_col_n = col_q;
      if (row_q < min_row_q) min_row_n = row_q;
      if (col_q > max_col_q) max_col_n = col_q;
      if (row_q > max_row_q) max_row_n = row_q;
    end
  end

  always_comb begin
    result_o.found = seen_n && trim_enable_i;
    if (result_o.found) begin
      lft = min_col_n;
      tp  = min_row_n;
      rgt = max_col_n;
      bot = max_row_n;
    end else begin
      lft = '0;
      tp  = '0;
      rgt = w_last;
      bot = h_last;
    end
    result_o.left           = lft;
    result_o.top            = tp;
    result_o.right          = rgt;
    result_o.bottom         = bot;
    result_o.trimmed_width  = DimW'(rgt) - DimW'(lft) + DimW'(1);
    result_o.trimmed_height = DimW'(bot) - DimW'(tp) + DimW'(1);
  end

  always_comb begin
    col_d     = col_q;
    row_d     = row_q;
    min_col_d = min_col_q;
    min_row_d = min_row_q;
    max_col_d = max_col_q;
    max_row_d = max_row_q;
    seen_d    = seen_q;
    if (step_i) begin
      if (!row_end) begin
        col_d = col_q + CoordW'(1);
      end else begin
        col_d = '0;
        row_d = frame_end_o ? '0 : row_q + CoordW'(1);
      end
      if (frame_end_o) begin
        min_col_d = '1;
        min_row_d = '1;
        max_col_d = '0;
        max_row_d = '0;
        seen_d    = 1'b0;
      end else begin
        min_col_d = min_col_n;
        min_row_d = min_row_n;
        max_col_d = max_col_n;
        max_row_d = max_row_n;
        seen_d    = seen_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      min_col_q <= '1;
      min_row_q <= '1;
      max_col_q <= '0;
      max_row_q <= '0;
      seen_q    <= 1'b0;
    end else begin
      col_q     <= col_d;
      row_q     <= row_d;
      min_col_q <= min_col_d;
      min_row_q <= min_row_d;
      max_col_q <= max_col_d;
      max_row_q <= max_row_d;
      seen_q    <= seen_d;
    end
  end

endmodule

>>> rtl/opaque_pixel_bounding_box.sv
// ----------------------------------------------------------------------------
// opaque_pixel_bounding_box
// Finds the bounding box of the opaque pixels in a raster-order RGBA frame.
// ----------------------------------------------------------------------------
// Takes one pixel per clock and emits one result word for each frame. The
// opacity test is made as a pixel enters the input register. When the pixel
// steps out of the input register the counter and bounds update runs, and
// for the last pixel of a frame it loads the result register, whose valid
// flag drives the output. The input stalls only when the last pixel of a
// frame sits in the input register while the previous frame's result word
// is still waiting to be taken. Frame geometry, threshold and trim enable
// come from the write port. Write them only while no pixel or result word
// is in flight. A change inside a frame applies from the next pixel, and
// trim enable is used when the frame ends.
module opaque_pixel_bounding_box
  import obb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // red [7:0], green [15:8], blue [23:16], alpha [31:24]
  input  logic [InDataW-1:0]  s_axis_tdata,

  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // found [0], left [12:1], top [24:13], right [36:25], bottom [48:37],
  // trimmed_width [61:49], trimmed_height [74:62], zero [79:75]
  output logic [OutDataW-1:0] m_axis_tdata,

  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic [DimW-1:0]  width_q, height_q;
  logic [ChanW-1:0] thresh_q;
  logic             trim_q;

  logic             in_valid_q, in_valid_d;
  logic             opaque_q, opaque_d;
  logic             out_valid_q, out_valid_d;
  obb_result_t      out_q, out_d;

  logic [ChanW-1:0] red, green, blue, alpha;
  logic             s_accept, step, proc_ok, frame_end;
  obb_result_t      result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DimW'(64);
      height_q <= DimW'(64);
      thresh_q <= ChanW'(8);
      trim_q   <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        CFG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        CFG_ALPHA_THRESH: thresh_q <= cfg_data_i[ChanW-1:0];
        CFG_TRIM_ENABLE:  trim_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign red   = s_axis_tdata[7:0];
  assign green = s_axis_tdata[15:8];
  assign blue  = s_axis_tdata[23:16];
  assign alpha = s_axis_tdata[31:24];

  // the pure red debug border never counts
  assign opaque_d = (alpha > thresh_q) &&
                    !(red == ChanMax && green == ChanMin && blue == ChanMin);

  // a frame end needs a free result register
  assign proc_ok       = !frame_end || !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && proc_ok;
  assign s_axis_tready = !in_valid_q || proc_ok;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  assign in_valid_d = s_accept ? 1'b1 : (step ? 1'b0 : in_valid_q);

  obb_tracker u_tracker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .opaque_i       (opaque_q),
    .image_width_i  (width_q),
    .image_height_i (height_q),
    .trim_enable_i  (trim_q),
    .frame_end_o    (frame_end),
    .result_o       (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (step && frame_end) begin
      out_valid_d = 1'b1;
      out_d       = result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      opaque_q <= opaque_d;
    end
    out_q <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0,
                          out_q.trimmed_height,
                          out_q.trimmed_width,
                          out_q.bottom,
                          out_q.right,
                          out_q.top,
                          out_q.left,
                          out_q.found};

endmodule
